// ===== rtl/uuidp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uuidp_pkg;

  localparam logic [7:0] HYPHEN_CHAR    = 8'h2D;
  localparam logic [7:0] LEN_HYPHENATED = 8'd36;
  localparam logic [7:0] LEN_PLAIN      = 8'd32;
  localparam logic [5:0] POS_MAX        = 6'd63;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LEN    = 2'd1,
    ST_BAD_HYPHEN = 2'd2,
    ST_BAD_HEX    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] character;
    logic [7:0] string_length;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
    status_t     status;
  } out_item_t;

  typedef struct packed {
    logic [5:0]   pos;
    logic [127:0] acc;
    logic         hyph_fmt;
    logic         len_bad;
    logic         hyphen_bad;
    logic         hex_bad;
  } parse_state_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nibble;
  } hex_digit_t;

  // ASCII hex digit decode; bad marks anything outside 0-9, a-f, A-F
  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t d;
    d.bad    = 1'b0;
    d.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.nibble = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d.nibble = c[3:0] + 4'd9;
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/uuidp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uuidp_core
  import uuidp_pkg::*;
(
  input  wire parse_state_t st,
  input  wire in_item_t     item,
  output parse_state_t      st_nxt,
  output out_item_t         res,
  output logic              res_valid
);

  logic       first;
  logic       hyph_fmt;
  logic       len_bad;
  logic [5:0] declared;
  logic       hyphen_slot;
  logic       in_range;
  hex_digit_t digit;
  logic [3:0] nib;
  logic [6:0] count;
  status_t    status;
  parse_state_t upd;

  always_comb begin
    first    = (st.pos == 6'd0);
    hyph_fmt = first ? (item.string_length == LEN_HYPHENATED) : st.hyph_fmt;
    len_bad  = first ? ((item.string_length != LEN_HYPHENATED) &&
                        (item.string_length != LEN_PLAIN)) : st.len_bad;
    declared = hyph_fmt ? LEN_HYPHENATED[5:0] : LEN_PLAIN[5:0];
    hyphen_slot = (st.pos == 6'd8) || (st.pos == 6'd13) ||
                  (st.pos == 6'd18) || (st.pos == 6'd23);
    in_range = !len_bad && (st.pos < declared);
    digit    = hex_value(item.character);
    nib      = digit.bad ? 4'd0 : digit.nibble;

    upd          = st;
    upd.hyph_fmt = hyph_fmt;
    upd.len_bad  = len_bad;
    if (in_range) begin
      if (hyph_fmt && hyphen_slot) begin
        if (item.character != HYPHEN_CHAR) upd.hyphen_bad = 1'b1;
      end else begin
        if (digit.bad) upd.hex_bad = 1'b1;
        upd.acc = {st.acc[123:0], nib};
      end
    end
    if (st.pos < POS_MAX) upd.pos = st.pos + 6'd1;

    // count includes this beat; a mismatch with the declared length is a length error
    count = {1'b0, st.pos} + 7'd1;
    if (len_bad || (count != {1'b0, declared})) status = ST_BAD_LEN;
    else if (upd.hyphen_bad) status = ST_BAD_HYPHEN;
    else if (upd.hex_bad) status = ST_BAD_HEX;
    else status = ST_OK;

    res.status    = status;
    res.uuid_high = (status == ST_OK) ? upd.acc[127:64] : 64'd0;
    res.uuid_low  = (status == ST_OK) ? upd.acc[63:0] : 64'd0;
    res_valid     = item.last;

    st_nxt = item.last ? '0 : upd;
  end

endmodule

`default_nettype wire

// ===== rtl/uuid_text_parser_top.sv =====
// The accepted last character is registered in the input register, then in the result register (or the skid).
// Throughput: one character per cycle while the skid is empty; one result beat per string, on its last character.
// A two-entry output (result register plus skid) keeps input flowing while a result waits.
// Reset (rst_n, synchronous, active low) empties all stages and returns the parser to position 0.
`timescale 1ns / 1ps
`default_nettype none

module uuid_text_parser_top
  import uuidp_pkg::*;
(
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output out_item_t      out_data
);

  logic         in_valid_r;
  in_item_t     in_r;
  parse_state_t st_r;
  parse_state_t st_nxt;
  out_item_t    res;
  logic         res_valid;
  logic         out_valid_r;
  out_item_t    out_r;
  logic         skid_valid_r;
  out_item_t    skid_r;
  logic         adv;
  logic         pop;

  uuidp_core u_core (
    .st        (st_r),
    .item      (in_r),
    .st_nxt    (st_nxt),
    .res       (res),
    .res_valid (res_valid)
  );

  assign adv      = in_valid_r && !skid_valid_r;
  assign in_ready = !in_valid_r || adv;
  assign pop      = out_valid_r && out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      st_r         <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (adv) st_r <= st_nxt;

      if (skid_valid_r) begin
        if (pop) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (adv && res_valid) begin
        if (!out_valid_r || out_ready) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
  end

  // skid only fills behind a stalled result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |->
      (out_r.uuid_high == 64'd0 && out_r.uuid_low == 64'd0))
    else $error("nonzero data on error status");

  a_last_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_r.last) |=> (st_r.pos == 6'd0 && !st_r.hex_bad && !st_r.hyphen_bad))
    else $error("parser state not cleared after last beat");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && skid_valid_r))
    else $error("input stalled without full output stages");

endmodule

`default_nettype wire

// ===== tb/uuid_text_parser_top_test.sv =====
`timescale 1ns / 1ps

module uuid_text_parser_top_test;
  import uuidp_pkg::*;

  typedef struct {
    string     text;
    logic [7:0] decl;
    bit        typed;
    out_item_t want;
  } text_row_t;

  localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
  localparam int    RANDOM_BEATS = 950;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  uuid_text_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // parser shadow state
  logic [5:0]  pos_cnt = '0;
  logic [63:0] acc_hi = '0;
  logic [63:0] acc_lo = '0;
  bit          fmt_hyph, len_err, hyph_err, hex_err;

  out_item_t   pending_uuids[$];
  out_item_t   oldest;
  logic [7:0]  text_buf[$];
  text_row_t   text_rows[$];
  text_row_t   row;
  int          send_idle = 18;
  int          recv_idle = 63;
  int          fails = 0;
  int          beats_counted = 0;
  int          kind, mut, len, slot;
  bit          hyph;
  logic [7:0]  decl;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic bit parse_char(input in_item_t it, output out_item_t res);
    logic [7:0] v;
    logic [3:0] nib;
    logic [5:0] was;
    int         declared;
    status_t    st;
    res = '0;
    if (pos_cnt == 0) begin
      fmt_hyph = (it.string_length == LEN_HYPHENATED);
      len_err  = !(it.string_length == LEN_HYPHENATED || it.string_length == LEN_PLAIN);
    end
    declared = fmt_hyph ? int'(LEN_HYPHENATED) : int'(LEN_PLAIN);
    if (!len_err && int'(pos_cnt) < declared) begin
      // hyphen slots of the 8-4-4-4-12 layout
      if (fmt_hyph && (pos_cnt == 8 || pos_cnt == 13 || pos_cnt == 18 || pos_cnt == 23)) begin
        if (it.character != HYPHEN_CHAR) hyph_err = 1'b1;
      end else begin
        v = 8'h00;
        if (it.character >= "0" && it.character <= "9") v = it.character - 8'h30;
        else if (it.character >= "a" && it.character <= "f") v = it.character - 8'h57;
        else if (it.character >= "A" && it.character <= "F") v = it.character - 8'h37;
        else hex_err = 1'b1;
        nib = v[3:0];
        {acc_hi, acc_lo} = {acc_hi[59:0], acc_lo, nib};
      end
    end
    was = pos_cnt;
    if (pos_cnt < POS_MAX) pos_cnt = pos_cnt + 6'd1;
    if (!it.last) return 1'b0;
    if (len_err || int'(was) + 1 != declared) st = ST_BAD_LEN;
    else if (hyph_err) st = ST_BAD_HYPHEN;
    else if (hex_err) st = ST_BAD_HEX;
    else st = ST_OK;
    res.status = st;
    if (st == ST_OK) begin
      res.uuid_high = acc_hi;
      res.uuid_low  = acc_lo;
    end
    pos_cnt  = '0;
    acc_hi   = '0;
    acc_lo   = '0;
    fmt_hyph = 1'b0;
    len_err  = 1'b0;
    hyph_err = 1'b0;
    hex_err  = 1'b0;
    return 1'b1;
  endfunction

  // Sends text_buf as one string; length rides on the first beat only.
  task automatic send_text(input logic [7:0] dlen, input bit typed, input out_item_t want);
    in_item_t  it;
    out_item_t res;
    int        n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      it.character     = text_buf[i];
      it.string_length = (i == 0) ? dlen : 8'($urandom);
      it.last          = (i == n - 1);
      while ($urandom_range(99) < send_idle) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= it;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      if (parse_char(it, res)) pending_uuids.push_back(typed ? want : res);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_uuids.size() == 0) begin
        $error("result beat with nothing expected: high %h low %h status %0d",
               out_data.uuid_high, out_data.uuid_low, out_data.status);
        fails++;
      end else begin
        oldest = pending_uuids.pop_front();
        if (out_data.uuid_high !== oldest.uuid_high) begin
          $error("uuid_high: expected %h, got %h", oldest.uuid_high, out_data.uuid_high);
          fails++;
        end
        if (out_data.uuid_low !== oldest.uuid_low) begin
          $error("uuid_low: expected %h, got %h", oldest.uuid_low, out_data.uuid_low);
          fails++;
        end
        if (out_data.status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_data.status);
          fails++;
        end
      end
    end
  end

  initial begin
    text_rows.push_back('{"00000000-0000-0000-0000-000000000000", LEN_HYPHENATED, 1'b1,
                          '{64'h0, 64'h0, ST_OK}});
    text_rows.push_back('{"ffffffff-ffff-ffff-ffff-ffffffffffff", LEN_HYPHENATED, 1'b1,
                          '{'1, '1, ST_OK}});
    text_rows.push_back('{"FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF", LEN_PLAIN, 1'b1,
                          '{'1, '1, ST_OK}});
    text_rows.push_back('{"0123456789abcdefABCDEF0123456789", LEN_PLAIN, 1'b0, '0});
    text_rows.push_back('{"12345678-9abc-DEF0-1234-56789abcdef0", LEN_HYPHENATED, 1'b0, '0});
    text_rows.push_back('{"a1B2c3D4-e5F6-0718-293a-4b5c6d7e8f90", LEN_HYPHENATED, 1'b0, '0});
    text_rows.push_back('{"12345678x9abc-def0-1234-56789abcdef0", LEN_HYPHENATED, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_HYPHEN}});
    text_rows.push_back('{"12345678-9abc-def0-1234056789abcdef0", LEN_HYPHENATED, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_HYPHEN}});
    text_rows.push_back('{"g2345678-9abc-def0-1234-56789abcdef0", LEN_HYPHENATED, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_HEX}});
    // hyphen error outranks hex error
    text_rows.push_back('{"g2345678-9abc+def0-1234-56789abcdef0", LEN_HYPHENATED, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_HYPHEN}});
    text_rows.push_back('{"12345678-9abcdef0123456789abcdef0", LEN_PLAIN, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_LEN}});
    text_rows.push_back('{"12345678-9abc-def01234567", LEN_PLAIN, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_LEN}});
    // six characters just outside the hex ranges and 0xFF, then 25 zeros
    text_rows.push_back('{{"/:@G`g\377", "00000000", "00000000", "00000000", "0"},
                          LEN_PLAIN, 1'b1, '{64'h0, 64'h0, ST_BAD_HEX}});
    text_rows.push_back('{"0123456789abcdef0123456789abc-ef", LEN_PLAIN, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_HEX}});
    text_rows.push_back('{"0", 8'd0, 1'b1, '{64'h0, 64'h0, ST_BAD_LEN}});
    text_rows.push_back('{"12345678-9abc-def0-1234-56789abcdef0", 8'd255, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_LEN}});
    text_rows.push_back('{"12345678-9abc-def0-1234-56789abcdef", 8'd35, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_LEN}});
    text_rows.push_back('{"12345678-9abc-def0-1234-56789abcdef01", 8'd37, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_LEN}});
    // short for the declared length
    text_rows.push_back('{"12345678-9abc-def0-1234-56789abcdef", LEN_HYPHENATED, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_LEN}});
    // surplus characters past the declared length
    text_rows.push_back('{"0123456789abcdef0123456789abcdef0", LEN_PLAIN, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_LEN}});
    text_rows.push_back('{"12345678-9abc-def0-1234-56789abcdef0", LEN_PLAIN, 1'b1,
                          '{64'h0, 64'h0, ST_BAD_LEN}});
    text_rows.push_back('{{"0123456789abcdef0123456789abcdef",
                           "0123456789abcdef0123456789abcdef", "012345"},
                          LEN_HYPHENATED, 1'b1, '{64'h0, 64'h0, ST_BAD_LEN}});
    text_rows.push_back('{"1", LEN_HYPHENATED, 1'b1, '{64'h0, 64'h0, ST_BAD_LEN}});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (text_rows[r]) begin
      row = text_rows[r];
      text_buf.delete();
      for (int k = 0; k < row.text.len(); k++) text_buf.push_back(row.text[k]);
      send_text(row.decl, row.typed, row.want);
    end

    while (beats_counted < RANDOM_BEATS) begin
      if (beats_counted < RANDOM_BEATS / 3) begin
        send_idle = 18;
        recv_idle = 63;
      end else if (beats_counted < 2 * RANDOM_BEATS / 3) begin
        send_idle = 63;
        recv_idle = 18;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      text_buf.delete();
      kind = $urandom_range(99);
      if (kind < 65) begin
        hyph = $urandom_range(1);
        decl = hyph ? LEN_HYPHENATED : LEN_PLAIN;
        for (int k = 0; k < int'(decl); k++) begin
          if (hyph && (k == 8 || k == 13 || k == 18 || k == 23)) text_buf.push_back(HYPHEN_CHAR);
          else text_buf.push_back(HEX_DIGITS[$urandom_range(HEX_DIGITS.len() - 1)]);
        end
        mut = $urandom_range(99);
        if (mut < 10) begin
          text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom);
        end else if (mut < 18 && hyph) begin
          slot = $urandom_range(3);
          text_buf[slot == 0 ? 8 : slot == 1 ? 13 : slot == 2 ? 18 : 23] =
            HEX_DIGITS[$urandom_range(HEX_DIGITS.len() - 1)];
        end else if (mut < 24) begin
          repeat ($urandom_range(1, 4)) void'(text_buf.pop_back());
        end else if (mut < 30) begin
          repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom));
        end
      end else if (kind < 80) begin
        // declared length neither format: everything up to last is ignored
        do decl = 8'($urandom); while (decl == LEN_HYPHENATED || decl == LEN_PLAIN);
        len = $urandom_range(1, 40);
        repeat (len) text_buf.push_back(8'($urandom));
      end else if (kind < 93) begin
        decl = $urandom_range(1) ? LEN_HYPHENATED : LEN_PLAIN;
        len = $urandom_range(1, 40);
        repeat (len) text_buf.push_back(8'($urandom));
      end else begin
        decl = $urandom_range(1) ? LEN_HYPHENATED : LEN_PLAIN;
        len = $urandom_range(60, 80);
        repeat (len) text_buf.push_back(HEX_DIGITS[$urandom_range(HEX_DIGITS.len() - 1)]);
      end
      send_text(decl, 1'b0, '0);
      beats_counted += text_buf.size();
    end

    in_valid <= 1'b0;
    while (pending_uuids.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
